/* rtl/skpr_pkg.sv */
// ----------------------------------------------------------------------------
// skpr_pkg - shared types and constants for the spectral kinetic phase rotator
// Field widths, configuration indexes, CORDIC constants and the config struct.
// ----------------------------------------------------------------------------
package skpr_pkg;

    localparam int MAX_AXIS     = 1024;
    localparam int SIZE_W       = 11;
    localparam int IDX_W        = 10;
    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 32;
    localparam int PHASE_W      = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    // folded frequency index and its square
    localparam int FREQ_W       = IDX_W + 2;
    localparam int SQ_W         = 21;

    // CORDIC
    localparam int CORDIC_STEPS = 24;
    localparam int NUM_STEPS    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int GAIN_W       = 33;
    localparam int GPROD_W      = SAMPLE_W + GAIN_W;
    localparam int DP_W         = 34;

    // limit CORDIC gain compensation, Q0.32
    localparam logic [GAIN_W-1:0] GAIN_Q32 = 33'h0_9B74_EDA8;

    // arctangent of 2^-i in Q0.32 turns
    localparam logic [PHASE_W-1:0] ATAN_TURNS [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Z = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd64;

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic [COEF_W-1:0] coef_x;
        logic [COEF_W-1:0] coef_y;
        logic [COEF_W-1:0] coef_z;
    } t_cfg;

endpackage

/* rtl/skpr_phase.sv */
// ----------------------------------------------------------------------------
// skpr_phase - kinetic phase from a 3-D grid index
// Folds, squares, scales by the per-axis coefficients and negates. 3 stages.
// ----------------------------------------------------------------------------
module skpr_phase (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [skpr_pkg::IDX_W-1:0]    i_index_x,
    input  logic [skpr_pkg::IDX_W-1:0]    i_index_y,
    input  logic [skpr_pkg::IDX_W-1:0]    i_index_z,
    input  skpr_pkg::t_cfg                i_cfg,
    output logic                          o_valid,
    output logic [skpr_pkg::PHASE_W-1:0]  o_phase
);
    import skpr_pkg::*;

    localparam int PROD_W = COEF_W + SQ_W;
    localparam logic [SQ_W-1:0] SQ_MAX = SQ_W'(MAX_AXIS * MAX_AXIS);

    // size 0 acts as 1, above MAX_AXIS as MAX_AXIS
    function automatic logic [SQ_W-1:0] fold_sq(input logic [SIZE_W-1:0] size,
                                                input logic [IDX_W-1:0]  idx);
        logic [SIZE_W-1:0]        n;
        logic [SIZE_W-1:0]        half;
        logic signed [FREQ_W-1:0] f;
        logic signed [2*FREQ_W-1:0] sq;
        n = size;
        if (n == '0) begin
            n = SIZE_W'(1);
        end else if (n > SIZE_W'(MAX_AXIS)) begin
            n = SIZE_W'(MAX_AXIS);
        end
        half = n >> 1;
        if ({1'b0, idx} <= half) begin
            f = signed'(FREQ_W'(idx));
        end else begin
            f = signed'(FREQ_W'(idx)) - signed'(FREQ_W'(n));
        end
        sq = f * f;
        return sq[SQ_W-1:0];
    endfunction

    logic [SQ_W-1:0]    r_sq_x, r_sq_y, r_sq_z;
    logic [PHASE_W-1:0] r_prod_x, r_prod_y, r_prod_z;
    logic [PHASE_W-1:0] r_phase;
    logic               r_va, r_vb, r_vc;

    logic [PROD_W-1:0]  n_full_x, n_full_y, n_full_z;
    logic [PHASE_W-1:0] n_phase;

    always_comb begin
        n_full_x = PROD_W'(i_cfg.coef_x) * PROD_W'(r_sq_x);
        n_full_y = PROD_W'(i_cfg.coef_y) * PROD_W'(r_sq_y);
        n_full_z = PROD_W'(i_cfg.coef_z) * PROD_W'(r_sq_z);
        // only the fraction of a turn matters, so everything wraps mod 2^32
        n_phase  = '0 - (r_prod_x + r_prod_y + r_prod_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_x   <= fold_sq(i_cfg.size_x, i_index_x);
            r_sq_y   <= fold_sq(i_cfg.size_y, i_index_y);
            r_sq_z   <= fold_sq(i_cfg.size_z, i_index_z);
            r_prod_x <= n_full_x[PHASE_W-1:0];
            r_prod_y <= n_full_y[PHASE_W-1:0];
            r_prod_z <= n_full_z[PHASE_W-1:0];
            r_phase  <= n_phase;
        end
    end

    assign o_valid = r_vc;
    assign o_phase = r_phase;

    // folded index stays within +/-1023, even for indexes beyond the grid
    a_sq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va |-> (r_sq_x <= SQ_MAX) && (r_sq_y <= SQ_MAX) && (r_sq_z <= SQ_MAX))
        else $error("squared frequency index out of range");

endmodule

/* rtl/skpr_cordic.sv */
// ----------------------------------------------------------------------------
// skpr_cordic - pipelined CORDIC rotator
// Quarter-turn pre-rotation, one stage per iteration, round and saturate.
// ----------------------------------------------------------------------------
module skpr_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [skpr_pkg::DP_W-1:0]    i_x,
    input  logic signed [skpr_pkg::DP_W-1:0]    i_y,
    input  logic [skpr_pkg::PHASE_W-1:0]        i_phase,
    output logic                                o_valid,
    output logic signed [skpr_pkg::SAMPLE_W-1:0] o_re,
    output logic signed [skpr_pkg::SAMPLE_W-1:0] o_im
);
    import skpr_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam int GUARD_W = 8;
    localparam int SH_W    = DP_W - GUARD_W;
    localparam logic signed [DP_W-1:0] RND      = DP_W'(1) <<< (GUARD_W - 1);
    localparam logic signed [DP_W-1:0] RESID_LIM = DP_W'(1) <<< (PHASE_W - 3);
    localparam logic signed [SH_W-1:0] SAT_HI   = SH_W'((1 <<< (SAMPLE_W - 1)) - 1);
    localparam logic signed [SH_W-1:0] SAT_LO   = -(SH_W'(1 <<< (SAMPLE_W - 1)));

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
            input logic signed [DP_W-1:0] v);
        logic signed [DP_W-1:0] r;
        logic signed [SH_W-1:0] s;
        r = v + RND;
        s = r[DP_W-1:GUARD_W];
        if (s > SAT_HI) begin
            return SAT_HI[SAMPLE_W-1:0];
        end else if (s < SAT_LO) begin
            return SAT_LO[SAMPLE_W-1:0];
        end
        return s[SAMPLE_W-1:0];
    endfunction

    logic signed [DP_W-1:0] r_x [0:NUM_STEPS];
    logic signed [DP_W-1:0] r_y [0:NUM_STEPS];
    logic signed [DP_W-1:0] r_z [0:NUM_STEPS];
    logic [NUM_STEPS:0]     r_v;
    logic signed [SAMPLE_W-1:0] r_re, r_im;
    logic                       r_vo;

    logic [PHASE_W-1:0]     w_ph_rnd;
    logic [1:0]             w_quad;
    logic [PHASE_W-1:0]     w_resid;
    logic signed [DP_W-1:0] n_x [0:NUM_STEPS];
    logic signed [DP_W-1:0] n_y [0:NUM_STEPS];
    logic signed [DP_W-1:0] n_z [0:NUM_STEPS];

    always_comb begin
        // nearest quarter turn, residual in [-1/8, 1/8) turn
        w_ph_rnd = i_phase + (PHASE_W'(1) << (PHASE_W - 3));
        w_quad   = w_ph_rnd[PHASE_W-1:PHASE_W-2];
        w_resid  = i_phase - {w_quad, {(PHASE_W-2){1'b0}}};
        n_z[0]   = DP_W'(signed'(w_resid));
        case (w_quad)
            QUAD_0: begin
                n_x[0] = i_x;
                n_y[0] = i_y;
            end
            QUAD_1: begin
                n_x[0] = -i_y;
                n_y[0] = i_x;
            end
            QUAD_2: begin
                n_x[0] = -i_x;
                n_y[0] = -i_y;
            end
            QUAD_3: begin
                n_x[0] = i_y;
                n_y[0] = -i_x;
            end
            default: begin
                n_x[0] = i_x;
                n_y[0] = i_y;
            end
        endcase

        // one micro-rotation per stage
        for (int k = 0; k < NUM_STEPS; k++) begin
            if (!r_z[k][DP_W-1]) begin
                n_x[k+1] = r_x[k] - (r_y[k] >>> k);
                n_y[k+1] = r_y[k] + (r_x[k] >>> k);
                n_z[k+1] = r_z[k] - signed'(DP_W'(ATAN_TURNS[k]));
            end else begin
                n_x[k+1] = r_x[k] + (r_y[k] >>> k);
                n_y[k+1] = r_y[k] - (r_x[k] >>> k);
                n_z[k+1] = r_z[k] + signed'(DP_W'(ATAN_TURNS[k]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[NUM_STEPS-1:0], i_valid};
            r_vo <= r_v[NUM_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= NUM_STEPS; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
            r_re <= round_sat(r_x[NUM_STEPS]);
            r_im <= round_sat(r_y[NUM_STEPS]);
        end
    end

    assign o_valid = r_vo;
    assign o_re    = r_re;
    assign o_im    = r_im;

    a_resid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_z[0] >= -RESID_LIM) && (r_z[0] < RESID_LIM))
        else $error("CORDIC residual outside one eighth of a turn");

endmodule

/* rtl/spectral_kinetic_phase_rotator_top.sv */
// ----------------------------------------------------------------------------
// spectral_kinetic_phase_rotator_top - split-step kinetic phase rotation
// Rotates one complex spectral bin by the kinetic phase of its grid index.
// ----------------------------------------------------------------------------
// Pipeline: phase path, quadrant register, one register per CORDIC iteration
//   (24 CORDIC steps), round/saturate register.
// Throughput: one transaction per cycle; the whole pipeline advances together
//   and holds while a result waits on the master side.
// Reset: synchronous, active low; clears all valid bits, sizes go to 64 and
//   coefficients to 0. The config port is always ready.
module spectral_kinetic_phase_rotator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: index_x[9:0], index_y[19:10], index_z[29:20],
    //             sample_re[53:30], sample_im[77:54], zero pad [79:78]
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,
    // master side: rotated_re[23:0], rotated_im[47:24]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [skpr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [skpr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import skpr_pkg::*;

    // tdata field offsets
    localparam int IX_LO = 0;
    localparam int IY_LO = IX_LO + IDX_W;
    localparam int IZ_LO = IY_LO + IDX_W;
    localparam int RE_LO = IZ_LO + IDX_W;
    localparam int IM_LO = RE_LO + SAMPLE_W;
    localparam int RSH_W = GPROD_W - SAMPLE_W;

    localparam logic signed [GPROD_W-1:0] GAIN_RND = GPROD_W'(1) <<< (SAMPLE_W - 1);

    // ------------------------------------------------------------------
    // Configuration registers. Writes to unused indexes are dropped.
    // ------------------------------------------------------------------
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_x <= SIZE_RESET;
            r_cfg.size_y <= SIZE_RESET;
            r_cfg.size_z <= SIZE_RESET;
            r_cfg.coef_x <= '0;
            r_cfg.coef_y <= '0;
            r_cfg.coef_z <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SIZE_X: r_cfg.size_x <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y: r_cfg.size_y <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z: r_cfg.size_z <= i_cfg_data[SIZE_W-1:0];
                CFG_COEF_X: r_cfg.coef_x <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_Y: r_cfg.coef_y <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_Z: r_cfg.coef_z <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable. Every stage moves when the output register is empty
    // or being drained, so a fresh transaction is taken in the same cycle
    // the previous result leaves.
    // ------------------------------------------------------------------
    logic w_en;

    assign w_en            = i_m_axis_tready || !o_m_axis_tvalid;
    assign o_s_axis_tready = w_en;

    // ------------------------------------------------------------------
    // Phase path: three stages (fold/square, scale, sum/negate).
    // ------------------------------------------------------------------
    logic               w_ph_valid;
    logic [PHASE_W-1:0] w_phase;

    skpr_phase u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_s_axis_tvalid),
        .i_index_x (i_s_axis_tdata[IX_LO +: IDX_W]),
        .i_index_y (i_s_axis_tdata[IY_LO +: IDX_W]),
        .i_index_z (i_s_axis_tdata[IZ_LO +: IDX_W]),
        .i_cfg     (r_cfg),
        .o_valid   (w_ph_valid),
        .o_phase   (w_phase)
    );

    // ------------------------------------------------------------------
    // Sample path, kept in step with the phase path: gain multiply,
    // round to 8 guard bits below Q1.23, one alignment register.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] w_re_in, w_im_in;
    logic signed [GPROD_W-1:0]  r_gx, r_gy;
    logic signed [DP_W-1:0]     r_sx, r_sy;
    logic signed [DP_W-1:0]     r_cx, r_cy;
    logic signed [GPROD_W-1:0]  w_gx_rnd, w_gy_rnd;
    logic signed [RSH_W-1:0]    w_gx_sh, w_gy_sh;

    assign w_re_in  = signed'(i_s_axis_tdata[RE_LO +: SAMPLE_W]);
    assign w_im_in  = signed'(i_s_axis_tdata[IM_LO +: SAMPLE_W]);
    assign w_gx_rnd = r_gx + GAIN_RND;
    assign w_gy_rnd = r_gy + GAIN_RND;
    assign w_gx_sh  = w_gx_rnd[GPROD_W-1:SAMPLE_W];
    assign w_gy_sh  = w_gy_rnd[GPROD_W-1:SAMPLE_W];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gx <= GPROD_W'(w_re_in) * signed'(GPROD_W'(GAIN_Q32));
            r_gy <= GPROD_W'(w_im_in) * signed'(GPROD_W'(GAIN_Q32));
            r_sx <= DP_W'(w_gx_sh);
            r_sy <= DP_W'(w_gy_sh);
            r_cx <= r_sx;
            r_cy <= r_sy;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation; its last stage is the output register.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] w_rot_re, w_rot_im;

    skpr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ph_valid),
        .i_x     (r_cx),
        .i_y     (r_cy),
        .i_phase (w_phase),
        .o_valid (o_m_axis_tvalid),
        .o_re    (w_rot_re),
        .o_im    (w_rot_im)
    );

    assign o_m_axis_tdata = {w_rot_im, w_rot_re};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_cfg_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && (i_cfg_index > CFG_COEF_Z)) |=> $stable(r_cfg))
        else $error("write to an unused config index changed a register");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && w_ph_valid) |=> $stable(r_cx) && $stable(r_cy) && $stable(w_phase))
        else $error("sample or phase moved during a stall");

endmodule
